// ===== rtl/fgpr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fgpr_pkg
// shared widths, register indexes and reset values of the glyph rasterizer
// ----------------------------------------------------------------------------
package fgpr_pkg;

  localparam int unsigned FontAddrW = 10;
  localparam int unsigned CharW     = 7;
  localparam int unsigned CoordW    = 16;
  localparam int unsigned ColorW    = 24;
  localparam int unsigned AddrW     = 32;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 32;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_FG_COLOR   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_BG_COLOR   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_FRAME_BASE = 2'd2;

  localparam logic [ColorW-1:0] FG_RESET   = 24'h000000;
  localparam logic [ColorW-1:0] BG_RESET   = 24'hFFFFFF;
  localparam logic [AddrW-1:0]  BASE_RESET = 32'h0000_0000;

  // input function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_DRAW = 1'b1;

endpackage : fgpr_pkg
`default_nettype wire

// ===== rtl/fgpr_stream_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fgpr stream interfaces
// command channel and pixel channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface fgpr_in_if
  import fgpr_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic                     func;
  logic [FontAddrW-1:0]     font_addr;
  logic [7:0]               font_byte;
  logic [CharW-1:0]         char_code;
  logic [CoordW-1:0]        row_origin;
  logic signed [CoordW-1:0] col_origin;

  modport source (
    output valid, func, font_addr, font_byte, char_code, row_origin, col_origin,
    input  ready
  );
  modport sink (
    input  valid, func, font_addr, font_byte, char_code, row_origin, col_origin,
    output ready
  );
endinterface : fgpr_in_if

interface fgpr_out_if
  import fgpr_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [AddrW-1:0]  pixel_addr;
  logic [ColorW-1:0] pixel_color;
  logic              pixel_write;
  logic              last_pixel;

  modport source (
    output valid, pixel_addr, pixel_color, pixel_write, last_pixel,
    input  ready
  );
  modport sink (
    input  valid, pixel_addr, pixel_color, pixel_write, last_pixel,
    output ready
  );
endinterface : fgpr_out_if
`default_nettype wire

// ===== rtl/fgpr_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fgpr_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module fgpr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic                                   re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule : fgpr_ram
`default_nettype wire

// ===== rtl/font_glyph_pixel_rasterizer_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// font_glyph_pixel_rasterizer_top
// 8x8 bitmap font store and rasterizer, one pixel transaction per glyph bit
// ----------------------------------------------------------------------------
// channel   dir  handshake        payload
// in_i      in   valid/ready      func, font_addr, font_byte, char_code,
//                                 row_origin, col_origin
// out_o     out  valid/ready      pixel_addr, pixel_color, pixel_write,
//                                 last_pixel
// cfg       in   cfg_we_i only    cfg_idx_i, cfg_data_i
//
// a load writes the byte straight into the font ram when its address is in range
// a draw: the accept cycle issues the first ram read, then the fetch state does
// the row term multiply, the addr state the start address, then 64 pixels at one
// per cycle, unless the output stalls, through the output register
// the next glyph row is fetched from the ram while the current one shifts out
// reset clears control and config only; font ram is undefined until loaded
// a stalled output freezes the pixel walk, new commands wait for the walk end
// ----------------------------------------------------------------------------
module font_glyph_pixel_rasterizer_top
  import fgpr_pkg::*;
#(
  parameter int unsigned GLYPH_COUNT = 128,
  parameter int unsigned SCREEN_ROWS = 768,
  parameter int unsigned SCREEN_COLS = 1024
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  fgpr_in_if.sink                  in_i,
  fgpr_out_if.source               out_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned StoreBytes = GLYPH_COUNT * 8;
  localparam int unsigned RamAw      = $clog2(StoreBytes);
  localparam logic [AddrW-1:0] ColStep = 32'd3;
  localparam logic [AddrW-1:0] RowStep = 32'(3 * SCREEN_COLS);
  localparam logic [AddrW-1:0] ColsW   = 32'(SCREEN_COLS);
  localparam logic [15:0]      ColsCmp = 16'(SCREEN_COLS);
  localparam logic [16:0]      RowsCmp = 17'(SCREEN_ROWS);

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FETCH = 2'd1;
  localparam logic [1:0] S_ADDR  = 2'd2;
  localparam logic [1:0] S_RUN   = 2'd3;

  logic [1:0] state_q, state_d;

  // configuration registers
  logic [ColorW-1:0] fg_q, bg_q;
  logic [AddrW-1:0]  base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q   <= FG_RESET;
      bg_q   <= BG_RESET;
      base_q <= BASE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FG_COLOR:   fg_q   <= cfg_data_i[ColorW-1:0];
        CFG_BG_COLOR:   bg_q   <= cfg_data_i[ColorW-1:0];
        CFG_FRAME_BASE: base_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // command acceptance
  logic in_acc, draw_acc, load_acc;
  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign draw_acc   = in_acc && (in_i.func == FUNC_DRAW);
  assign load_acc   = in_acc && (in_i.func == FUNC_LOAD);

  // latched draw parameters
  logic [CharW-1:0]  glyph_q;
  logic              glyph_ok_q;
  logic [CoordW-1:0] row0_q;
  logic [CoordW-1:0] col0_q;
  logic [AddrW-1:0]  lin_q;

  // pixel walk
  logic [5:0]       pix_cnt_q;
  logic [2:0]       pk, pj;
  logic [7:0]       cur_q;
  logic [AddrW-1:0] row_addr_q, pix_addr_q;
  logic             gen;
  logic             row_end;

  assign pk      = pix_cnt_q[5:3];
  assign pj      = pix_cnt_q[2:0];
  assign row_end = (pj == 3'd7);

  // output register
  logic              ov_q;
  logic [AddrW-1:0]  oaddr_q;
  logic [ColorW-1:0] ocolor_q;
  logic              owrite_q, olast_q;

  assign gen = (state_q == S_RUN) && (!ov_q || out_o.ready);

  // font ram ports
  logic             ram_we, ram_re;
  logic [RamAw-1:0] ram_waddr, ram_raddr;
  logic [7:0]       ram_rdata, row_bits;
  logic [2:0]       rd_row;
  logic [CharW-1:0] rd_glyph;

  assign ram_we    = load_acc && ({2'b00, in_i.font_addr} < 12'(StoreBytes));
  assign ram_waddr = RamAw'(in_i.font_addr);

  // row 0 on accept, row 1 when the walk starts, row k+2 at the end of row k for k < 6
  assign ram_re = draw_acc || (state_q == S_ADDR) || (gen && row_end && (pk < 3'd6));
  always_comb begin
    unique case (state_q)
      S_IDLE:  rd_row = 3'd0;
      S_ADDR:  rd_row = 3'd1;
      default: rd_row = pk + 3'd2;
    endcase
  end
  assign rd_glyph  = (state_q == S_IDLE) ? in_i.char_code : glyph_q;
  assign ram_raddr = RamAw'({rd_glyph, rd_row});
  // glyphs beyond the store draw as all background
  assign row_bits  = glyph_ok_q ? ram_rdata : 8'h00;

  fgpr_ram #(
    .WIDTH (8),
    .DEPTH (StoreBytes)
  ) u_font_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_i.font_byte),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // screen position of the pixel being generated, for clipping
  logic [16:0] col_v, row_v;
  logic        on_screen;
  assign col_v     = {col0_q[15], col0_q} + {14'b0, pj};
  assign row_v     = {1'b0, row0_q} + {14'b0, pk};
  assign on_screen = !col_v[16] && (col_v[15:0] < ColsCmp) && (row_v < RowsCmp);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (draw_acc) state_d = S_FETCH;
      S_FETCH: state_d = S_ADDR;
      S_ADDR:  state_d = S_RUN;
      S_RUN:   if (gen && (pix_cnt_q == 6'd63)) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      pix_cnt_q <= '0;
      ov_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_ADDR) begin
        pix_cnt_q <= '0;
      end else if (gen) begin
        pix_cnt_q <= pix_cnt_q + 6'd1;
      end
      if (gen) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk_i) begin
    if (draw_acc) begin
      glyph_q    <= in_i.char_code;
      glyph_ok_q <= ({1'b0, in_i.char_code} < 9'(GLYPH_COUNT));
      row0_q     <= in_i.row_origin;
      col0_q     <= in_i.col_origin;
    end
    // linear pixel index of the glyph origin, wrapping at 32 bits
    if (state_q == S_FETCH) begin
      lin_q <= {{16{col0_q[15]}}, col0_q} + ({16'b0, row0_q} * ColsW);
    end
    if (state_q == S_ADDR) begin
      row_addr_q <= base_q + lin_q + {lin_q[AddrW-2:0], 1'b0};
      pix_addr_q <= base_q + lin_q + {lin_q[AddrW-2:0], 1'b0};
      cur_q      <= row_bits;
    end else if (gen) begin
      oaddr_q  <= pix_addr_q;
      ocolor_q <= cur_q[7] ? fg_q : bg_q;
      owrite_q <= on_screen;
      olast_q  <= (pix_cnt_q == 6'd63);
      if (row_end) begin
        cur_q      <= row_bits;
        row_addr_q <= row_addr_q + RowStep;
        pix_addr_q <= row_addr_q + RowStep;
      end else begin
        cur_q      <= {cur_q[6:0], 1'b0};
        pix_addr_q <= pix_addr_q + ColStep;
      end
    end
  end

  assign out_o.valid       = ov_q;
  assign out_o.pixel_addr  = oaddr_q;
  assign out_o.pixel_color = ocolor_q;
  assign out_o.pixel_write = owrite_q;
  assign out_o.last_pixel  = olast_q;

  // font writes only happen between draws
  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_IDLE))
    else $error("font ram written during a draw");

  // every walk starts at pixel zero
  a_walk_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ADDR) |=> (state_q == S_RUN) && (pix_cnt_q == 6'd0))
    else $error("pixel walk did not start at zero");

  // last pixel ends the walk
  a_walk_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gen && (pix_cnt_q == 6'd63)) |=> (state_q == S_IDLE) && ov_q && olast_q)
    else $error("walk did not end after the last pixel");

  // the row after next is fetched at the end of each of rows 0 to 5
  a_row_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gen && row_end && (pk < 3'd6)) |-> ram_re && (rd_row == pk + 3'd2))
    else $error("missing glyph row prefetch");

endmodule : font_glyph_pixel_rasterizer_top
`default_nettype wire
